### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Field widths, fixed-point constants and request/result types.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_BITS      = 16;
	localparam int FRACTION_BITS = 16;

	localparam int HUE_W = HUE_BITS;
	localparam int SAT_W = FRACTION_BITS + 1;
	localparam int CH_W  = 8;

	// 255 * brightness
	localparam int M_W = SAT_W + CH_W;
	// level weight, at most 2^(FRACTION_BITS + HUE_BITS)
	localparam int A_W  = FRACTION_BITS + HUE_BITS + 1;
	localparam int LO_W = A_W / 2;
	localparam int HI_W = A_W - LO_W;
	localparam int SHIFT = 2 * FRACTION_BITS + HUE_BITS;
	localparam int SUM_W = M_W + A_W + 1;
	localparam int LVL_W = SUM_W - SHIFT;

	localparam logic [HUE_W:0]   HUE_ONE  = (HUE_W + 1)'(1) << HUE_W;
	localparam logic [SAT_W-1:0] FRAC_ONE = SAT_W'(1) << FRACTION_BITS;
	localparam logic [A_W-1:0]   A_ONE    = A_W'(1) << (A_W - 1);

	// level lanes
	localparam int NUM_LV = 4;
	localparam int LV_V   = 0;
	localparam int LV_P   = 1;
	localparam int LV_Q   = 2;
	localparam int LV_T   = 3;

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [SAT_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

endpackage

### sv/hsv_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter
// Converts one HSV request per cycle to an 8-bit-per-channel RGB pixel.
// ----------------------------------------------------------------------------
// Pipeline: a request taken at a clock edge passes through the stages sector
// split, level weights, products and round; its pixel then shows on rgb with
// done high.
// Throughput: one request every cycle; busy stays low, nothing stalls.
// Reset: arst_n clears the stage valid bits and done; data is not reset.
`include "assert_macros.svh"

module hsv_to_rgb_pixel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hsv2rgb_pkg::hsv_t  hsv,
	output logic               done,
	output hsv2rgb_pkg::rgb_t  rgb
);

	localparam int HUE_W = hsv2rgb_pkg::HUE_W;
	localparam int SAT_W = hsv2rgb_pkg::SAT_W;
	localparam int CH_W  = hsv2rgb_pkg::CH_W;
	localparam int M_W   = hsv2rgb_pkg::M_W;
	localparam int A_W   = hsv2rgb_pkg::A_W;
	localparam int LO_W  = hsv2rgb_pkg::LO_W;
	localparam int HI_W  = hsv2rgb_pkg::HI_W;
	localparam int SUM_W = hsv2rgb_pkg::SUM_W;
	localparam int LVL_W = hsv2rgb_pkg::LVL_W;
	localparam int SHIFT = hsv2rgb_pkg::SHIFT;
	localparam int NUM_LV = hsv2rgb_pkg::NUM_LV;
	localparam int H6_W  = HUE_W + 3;
	localparam int PT_W  = A_W + 1;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SHIFT - 1);

	logic accept;

	// stage 1: sector and fraction, 255 * brightness
	logic [H6_W-1:0]      h6;
	logic [M_W-1:0]       m_in;
	logic                 valid_s1;
	hsv2rgb_pkg::sector_t sector_s1;
	logic [HUE_W-1:0]     f_s1;
	logic [SAT_W-1:0]     sat_s1;
	logic [M_W-1:0]       m_s1;

	// stage 2: level weights
	logic [HUE_W:0]       f_inv;
	logic [A_W-1:0]       prod_q;
	logic [PT_W-1:0]      prod_t;
	logic [A_W-1:0]       a_nxt [NUM_LV];
	logic                 valid_s2;
	hsv2rgb_pkg::sector_t sector_s2;
	logic [M_W-1:0]       m_s2;
	logic [A_W-1:0]       a_s2 [NUM_LV];

	// stage 3: partial products
	logic                 valid_s3;
	hsv2rgb_pkg::sector_t sector_s3;
	logic [M_W+HI_W-1:0]  ph_s3 [NUM_LV];
	logic [M_W+LO_W-1:0]  pl_s3 [NUM_LV];

	// stage 4: rounded levels and channel select
	logic [SUM_W-1:0]     sum [NUM_LV];
	logic [LVL_W-1:0]     lvl_raw [NUM_LV];
	logic [CH_W-1:0]      lvl [NUM_LV];
	hsv2rgb_pkg::rgb_t    rgb_nxt;
	logic                 valid_s4;
	hsv2rgb_pkg::rgb_t    rgb_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		h6   = (H6_W'(hsv.hue) << 2) + (H6_W'(hsv.hue) << 1);
		m_in = (M_W'(hsv.brightness) << CH_W) - M_W'(hsv.brightness);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= hsv2rgb_pkg::sector_t'(h6[H6_W-1:HUE_W]);
		f_s1      <= h6[HUE_W-1:0];
		sat_s1    <= hsv.saturation;
		m_s1      <= m_in;
	end

	// weights: v = 1, p = 1-S, q = 1-S*f, t = 1-S*(1-f); drop negatives to zero
	always_comb begin
		f_inv  = hsv2rgb_pkg::HUE_ONE - (HUE_W + 1)'(f_s1);
		prod_q = A_W'(sat_s1) * A_W'(f_s1);
		prod_t = PT_W'(sat_s1) * PT_W'(f_inv);
		a_nxt[hsv2rgb_pkg::LV_V] = hsv2rgb_pkg::A_ONE;
		if (sat_s1 >= hsv2rgb_pkg::FRAC_ONE) begin
			a_nxt[hsv2rgb_pkg::LV_P] = '0;
		end else begin
			a_nxt[hsv2rgb_pkg::LV_P] = {hsv2rgb_pkg::FRAC_ONE - sat_s1, HUE_W'(0)};
		end
		if (prod_q >= hsv2rgb_pkg::A_ONE) begin
			a_nxt[hsv2rgb_pkg::LV_Q] = '0;
		end else begin
			a_nxt[hsv2rgb_pkg::LV_Q] = hsv2rgb_pkg::A_ONE - prod_q;
		end
		if (prod_t >= PT_W'(hsv2rgb_pkg::A_ONE)) begin
			a_nxt[hsv2rgb_pkg::LV_T] = '0;
		end else begin
			a_nxt[hsv2rgb_pkg::LV_T] = hsv2rgb_pkg::A_ONE - prod_t[A_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		m_s2      <= m_s1;
		a_s2      <= a_nxt;
	end

	// split each weight in halves to keep multipliers narrow
	always_ff @(posedge clk) begin
		sector_s3 <= sector_s2;
		for (int i = 0; i < NUM_LV; i++) begin
			ph_s3[i] <= (M_W + HI_W)'(m_s2) * (M_W + HI_W)'(a_s2[i][A_W-1:LO_W]);
			pl_s3[i] <= (M_W + LO_W)'(m_s2) * (M_W + LO_W)'(a_s2[i][LO_W-1:0]);
		end
	end

	// round half up, then clamp to full scale
	always_comb begin
		for (int i = 0; i < NUM_LV; i++) begin
			sum[i] = (SUM_W'(ph_s3[i]) << LO_W) + SUM_W'(pl_s3[i]) + ROUND_HALF;
			lvl_raw[i] = sum[i][SUM_W-1:SHIFT];
			if (|lvl_raw[i][LVL_W-1:CH_W]) begin
				lvl[i] = '1;
			end else begin
				lvl[i] = lvl_raw[i][CH_W-1:0];
			end
		end
		case (sector_s3)
			hsv2rgb_pkg::SEC_R_Y: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_V], lvl[hsv2rgb_pkg::LV_T],
					lvl[hsv2rgb_pkg::LV_P]};
			end
			hsv2rgb_pkg::SEC_Y_G: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_Q], lvl[hsv2rgb_pkg::LV_V],
					lvl[hsv2rgb_pkg::LV_P]};
			end
			hsv2rgb_pkg::SEC_G_C: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_P], lvl[hsv2rgb_pkg::LV_V],
					lvl[hsv2rgb_pkg::LV_T]};
			end
			hsv2rgb_pkg::SEC_C_B: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_P], lvl[hsv2rgb_pkg::LV_Q],
					lvl[hsv2rgb_pkg::LV_V]};
			end
			hsv2rgb_pkg::SEC_B_M: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_T], lvl[hsv2rgb_pkg::LV_P],
					lvl[hsv2rgb_pkg::LV_V]};
			end
			default: begin
				rgb_nxt = {lvl[hsv2rgb_pkg::LV_V], lvl[hsv2rgb_pkg::LV_P],
					lvl[hsv2rgb_pkg::LV_Q]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rgb_s4 <= rgb_nxt;
	end

	assign done = valid_s4;
	assign rgb  = rgb_s4;

	`ASSERT_PROP(a_req_to_done, clk, arst_n, accept |-> ##4 done)
	`ASSERT_PROP(a_grey_on_zero_sat, clk, arst_n,
		(valid_s1 && sat_s1 == '0) |-> ##3 (rgb.red == rgb.green && rgb.green == rgb.blue))
	`ASSERT_PROP(a_black_on_zero_val, clk, arst_n,
		(accept && hsv.brightness == '0) |-> ##4 (rgb == '0))
	`ASSERT_NEVER(a_weight_above_v, clk, arst_n,
		valid_s2 && (a_s2[hsv2rgb_pkg::LV_P] > a_s2[hsv2rgb_pkg::LV_V] ||
		a_s2[hsv2rgb_pkg::LV_Q] > a_s2[hsv2rgb_pkg::LV_V] ||
		a_s2[hsv2rgb_pkg::LV_T] > a_s2[hsv2rgb_pkg::LV_V]))

endmodule
